FILE: sv/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types and constants for the text marquee scroller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tms_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int MAX_TEXT  = 64;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int TXT_AW    = $clog2(MAX_TEXT);
    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 7;

    localparam logic [CHAR_W-1:0] SPACE = 8'h20;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_WRITE   = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_TEXT_LENGTH  = 2'd0,
        REG_WINDOW_WIDTH = 2'd1,
        REG_PERIOD       = 2'd2,
        REG_DIRECTION    = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_OUT  = 2'd1,
        ST_SEND = 2'd2
    } state_t;

    // window memory control from the sequencer
    typedef struct packed {
        logic              clear;
        logic              we;
        logic [COL_W-1:0]  waddr;
        logic [CHAR_W-1:0] wdata;
        logic [COL_W-1:0]  raddr;
    } win_ctl_t;

endpackage

`default_nettype wire

FILE: sv/tms_window.sv
// ----------------------------------------------------------------------------
// tms_window
// Window character memory with registered read. Per-entry valid bits
// make unwritten or cleared entries read as a space.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tms_window (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire tms_pkg::win_ctl_t           ctl,
    output logic [tms_pkg::CHAR_W-1:0]       rdata
);

    logic [tms_pkg::CHAR_W-1:0]    mem [tms_pkg::MAX_WIDTH];
    logic [tms_pkg::MAX_WIDTH-1:0] vld_reg;
    logic [tms_pkg::CHAR_W-1:0]    rdata_reg;
    logic                          rvld_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rdata_reg <= mem[ctl.raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end else begin
            if (ctl.we) begin
                vld_reg[ctl.waddr] <= 1'b1;
            end
            rvld_reg <= vld_reg[ctl.raddr];
        end
    end

    assign rdata = rvld_reg ? rdata_reg : tms_pkg::SPACE;

endmodule

`default_nettype wire

FILE: sv/text_marquee_scroller.sv
// ----------------------------------------------------------------------------
// text_marquee_scroller
// Scrolls a stored text through a window: shift-in phase, then ring rotate.
// ----------------------------------------------------------------------------
// Frame: a firing tick moves IDLE to OUT, and its first word is shown in SEND.
// Per output word: registered read of one window column in OUT, then write-back
//   and output register, held in SEND until accepted, with no overlap between
//   columns; input is taken only in IDLE, so no item is taken during a frame.
// Reset: synchronous, active low; window reads as spaces via valid bits,
//   registers return to defaults, text memory is left as is.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_marquee_scroller (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [5:0] text_index, [13:6] text_char
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [5:0] column, [13:6] glyph
    output logic             m_tlast
);

    localparam int CW = tms_pkg::COL_W;
    localparam int LW = tms_pkg::LEN_W;
    localparam int DW = tms_pkg::CHAR_W;
    localparam int AW = tms_pkg::TXT_AW;

    // configuration registers
    logic [LW-1:0] text_length_reg;
    logic [LW-1:0] window_width_reg;
    logic [7:0]    period_reg;
    logic          direction_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_length_reg  <= LW'(1);
            window_width_reg <= LW'(16);
            period_reg       <= '0;
            direction_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (tms_pkg::reg_idx_t'(cfg_addr))
                tms_pkg::REG_TEXT_LENGTH:  text_length_reg  <= cfg_wdata[LW-1:0];
                tms_pkg::REG_WINDOW_WIDTH: window_width_reg <= cfg_wdata[LW-1:0];
                tms_pkg::REG_PERIOD:       period_reg       <= cfg_wdata;
                tms_pkg::REG_DIRECTION:    direction_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // effective length, width, ring size
    logic [LW-1:0] len, wid, ring_sz;
    always_comb begin
        if (text_length_reg == '0)
            len = LW'(1);
        else if (text_length_reg > LW'(tms_pkg::MAX_TEXT))
            len = LW'(tms_pkg::MAX_TEXT);
        else
            len = text_length_reg;
        if (window_width_reg == '0)
            wid = LW'(1);
        else if (window_width_reg > LW'(tms_pkg::MAX_WIDTH))
            wid = LW'(tms_pkg::MAX_WIDTH);
        else
            wid = window_width_reg;
        ring_sz = (len > wid) ? len : wid;
    end

    // input fields
    tms_pkg::kind_t kind;
    logic [AW-1:0]  in_index;
    logic [DW-1:0]  in_char;
    assign kind     = tms_pkg::kind_t'(s_tuser);
    assign in_index = s_tdata[AW-1:0];
    assign in_char  = s_tdata[AW+DW-1:AW];

    // state
    tms_pkg::state_t state_reg, state_next;
    logic [LW-1:0] shift_cnt_reg, shift_cnt_next;
    logic [CW-1:0] ring_pos_reg, ring_pos_next;
    logic [7:0]    tick_reg, tick_next;
    // per-frame sequencer
    logic          frame_shift_reg, frame_shift_next;
    logic [LW-1:0] c_reg, c_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] k_reg, k_next;
    logic [DW-1:0] prev_reg, prev_next;
    logic [DW-1:0] glyph_reg, glyph_next;
    logic          last_reg, last_next;

    logic in_acc, out_acc, fire, col_last, restart;
    logic [DW-1:0] win_rd, glyph_new;
    logic [DW-1:0] text_rd_reg;
    logic [AW-1:0] text_raddr;
    logic [DW-1:0] text_mem [tms_pkg::MAX_TEXT];
    tms_pkg::win_ctl_t win_ctl;

    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign fire     = in_acc && (kind == tms_pkg::KIND_TICK) && !(tick_reg < period_reg);
    assign restart  = in_acc && (kind == tms_pkg::KIND_RESTART);
    assign col_last = ({1'b0, col_reg} + LW'(1)) == wid;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tms_pkg::ST_IDLE: if (fire) state_next = tms_pkg::ST_OUT;
            tms_pkg::ST_OUT:  state_next = tms_pkg::ST_SEND;
            tms_pkg::ST_SEND: begin
                if (out_acc) state_next = col_last ? tms_pkg::ST_IDLE : tms_pkg::ST_OUT;
            end
            default: state_next = tms_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready = (state_reg == tms_pkg::ST_IDLE);
        m_tvalid = (state_reg == tms_pkg::ST_SEND);
    end

    // glyph for column col_reg, from the words read last cycle
    always_comb begin
        if (frame_shift_reg) begin
            if (direction_reg) begin
                if (col_reg == '0)
                    glyph_new = text_rd_reg;
                else if ({1'b0, col_reg} < c_reg)
                    glyph_new = prev_reg;
                else
                    glyph_new = win_rd;
            end else begin
                glyph_new = col_last ? text_rd_reg : win_rd;
            end
        end else begin
            glyph_new = ({1'b0, k_reg} < len) ? text_rd_reg : tms_pkg::SPACE;
        end
    end

    // datapath next values
    logic [LW-1:0] c_fire, p_eff, k_inc;
    always_comb begin
        c_fire = shift_cnt_reg;
        if (c_fire > len) c_fire = len;
        if (c_fire > wid) c_fire = wid;
        p_eff  = ({1'b0, ring_pos_reg} >= ring_sz) ? '0 : {1'b0, ring_pos_reg};
        k_inc  = {1'b0, k_reg} + LW'(1);

        shift_cnt_next   = shift_cnt_reg;
        ring_pos_next    = ring_pos_reg;
        tick_next        = tick_reg;
        frame_shift_next = frame_shift_reg;
        c_next           = c_reg;
        col_next         = col_reg;
        k_next           = k_reg;
        prev_next        = prev_reg;
        glyph_next       = glyph_reg;
        last_next        = last_reg;

        if (restart) begin
            shift_cnt_next = LW'(1);
            ring_pos_next  = '0;
            tick_next      = period_reg;
        end else if (in_acc && kind == tms_pkg::KIND_TICK) begin
            if (!fire) begin
                tick_next = tick_reg + 8'd1;
            end else begin
                tick_next        = '0;
                frame_shift_next = (shift_cnt_reg != '0);
                c_next           = c_fire;
                col_next         = '0;
                k_next           = p_eff[CW-1:0];
                if (shift_cnt_reg != '0) begin
                    shift_cnt_next = (c_fire == len || c_fire == wid) ? '0
                                                                      : c_fire + LW'(1);
                end else if (direction_reg) begin
                    ring_pos_next = (p_eff == '0) ? CW'(ring_sz - LW'(1))
                                                  : CW'(p_eff - LW'(1));
                end else begin
                    ring_pos_next = ((p_eff + LW'(1)) >= ring_sz) ? '0
                                                                  : CW'(p_eff + LW'(1));
                end
            end
        end

        if (state_reg == tms_pkg::ST_OUT) begin
            prev_next  = win_rd;
            glyph_next = glyph_new;
            last_next  = col_last;
        end
        if (state_reg == tms_pkg::ST_SEND && out_acc && !col_last) begin
            col_next = col_reg + CW'(1);
            k_next   = (k_inc >= ring_sz) ? '0 : k_inc[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= tms_pkg::ST_IDLE;
            shift_cnt_reg   <= LW'(1);
            ring_pos_reg    <= '0;
            tick_reg        <= '0;  // period resets to 0
            frame_shift_reg <= 1'b0;
            c_reg           <= '0;
            col_reg         <= '0;
            k_reg           <= '0;
        end else begin
            state_reg       <= state_next;
            shift_cnt_reg   <= shift_cnt_next;
            ring_pos_reg    <= ring_pos_next;
            tick_reg        <= tick_next;
            frame_shift_reg <= frame_shift_next;
            c_reg           <= c_next;
            col_reg         <= col_next;
            k_reg           <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg  <= prev_next;
        glyph_reg <= glyph_next;
        last_reg  <= last_next;
    end

    // read addresses follow the column about to be processed
    logic [LW-1:0] c_rd, col_rd;
    always_comb begin
        c_rd   = c_next;
        col_rd = {1'b0, col_next};
        if (frame_shift_next)
            text_raddr = direction_reg ? AW'(len - c_rd) : AW'(c_rd - LW'(1));
        else
            text_raddr = k_next;

        win_ctl.clear = restart;
        win_ctl.we    = (state_reg == tms_pkg::ST_OUT);
        win_ctl.waddr = col_reg;
        win_ctl.wdata = glyph_new;
        // leftward shift pulls from the right-hand neighbor
        if (frame_shift_next && !direction_reg && (col_rd >= wid - c_rd)
                && (col_rd + LW'(1) < wid))
            win_ctl.raddr = col_next + CW'(1);
        else
            win_ctl.raddr = col_next;
    end

    always_ff @(posedge aclk) begin
        if (in_acc && kind == tms_pkg::KIND_WRITE) begin
            text_mem[in_index] <= in_char;
        end
        text_rd_reg <= text_mem[text_raddr];
    end

    tms_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (win_ctl),
        .rdata   (win_rd)
    );

    assign m_tdata = {2'b00, glyph_reg, col_reg};
    assign m_tlast = last_reg;

    // checks
    a_out_then_send: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tms_pkg::ST_OUT |=> state_reg == tms_pkg::ST_SEND)
        else $error("column result not presented after compute");

    a_fire_starts_col0: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (col_reg == '0) && (state_reg == tms_pkg::ST_OUT))
        else $error("frame did not start at column 0");

    a_col_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, col_reg} < wid))
        else $error("column beyond window width");

    a_next_col: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && !m_tlast |=> (col_reg == $past(col_reg) + CW'(1))
                                && (state_reg == tms_pkg::ST_OUT))
        else $error("column sequence broken");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && m_tlast |=> s_tready)
        else $error("not idle after frame end");

endmodule

`default_nettype wire

FILE: bench/marquee_frame_checker.sv
// ----------------------------------------------------------------------------
// marquee_frame_checker
// Watches the config port and both streams of the marquee scroller, keeps
// its own copy of the text, window and scroll state, works out the window
// words each accepted tick should produce and compares every output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module marquee_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] text_index, [13:6] text_char
    input  logic [1:0]  s_tuser,   // [1:0] kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [5:0] column, [13:6] glyph
    input  logic        m_tlast,
    output int          errors,
    output int          pending,
    output int          frames_seen,
    output int          glyphs_seen
);

    typedef struct packed {
        logic [tms_pkg::COL_W-1:0]  column;
        logic [tms_pkg::CHAR_W-1:0] glyph;
        logic                       last;
    } glyph_word_t;

    logic [tms_pkg::CHAR_W-1:0] text_mem [tms_pkg::MAX_TEXT];
    logic [tms_pkg::CHAR_W-1:0] win_mem  [tms_pkg::MAX_WIDTH];
    int unsigned       ring_pos;
    int unsigned       shift_cnt;
    int unsigned       tick_cnt;

    logic [tms_pkg::LEN_W-1:0] cfg_len;
    logic [tms_pkg::LEN_W-1:0] cfg_width;
    logic [7:0]        cfg_period;
    logic              cfg_dir;

    glyph_word_t       glyph_q [$];

    initial begin
        errors      = 0;
        pending     = 0;
        frames_seen = 0;
        glyphs_seen = 0;
        for (int i = 0; i < tms_pkg::MAX_TEXT; i++) text_mem[i] = '0;
    end

    function automatic int unsigned saturate(logic [tms_pkg::LEN_W-1:0] v,
                                             int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic restart_scroll();
        for (int i = 0; i < tms_pkg::MAX_WIDTH; i++) win_mem[i] = tms_pkg::SPACE;
        ring_pos  = 0;
        shift_cnt = 1;
        tick_cnt  = cfg_period;
    endtask

    // one accepted input word: update state, queue the frame if the tick fires
    task automatic advance_marquee(tms_pkg::kind_t k, logic [5:0] idx, logic [7:0] ch);
        int unsigned len, w, c, r, p, i, ki;
        glyph_word_t gw;
        case (k)
            tms_pkg::KIND_WRITE: text_mem[idx] = ch;
            tms_pkg::KIND_RESTART: restart_scroll();
            tms_pkg::KIND_TICK: begin
                if (tick_cnt < cfg_period) begin
                    tick_cnt++;
                end else begin
                    tick_cnt = 0;
                    len = saturate(cfg_len, tms_pkg::MAX_TEXT);
                    w   = saturate(cfg_width, tms_pkg::MAX_WIDTH);
                    if (shift_cnt != 0) begin
                        c = shift_cnt;
                        if (c > len) c = len;
                        if (c > w) c = w;
                        if (cfg_dir) begin
                            for (i = c - 1; i >= 1; i--) win_mem[i] = win_mem[i-1];
                            win_mem[0] = text_mem[len-c];
                        end else begin
                            for (i = w - c; i + 1 < w; i++) win_mem[i] = win_mem[i+1];
                            win_mem[w-1] = text_mem[c-1];
                        end
                        shift_cnt = (c == len || c == w) ? 0 : c + 1;
                    end else begin
                        r = (len > w) ? len : w;
                        p = ring_pos;
                        if (p >= r) p = 0;   // left over from a larger ring
                        for (i = 0; i < w; i++) begin
                            ki = (p + i) % r;
                            win_mem[i] = (ki < len) ? text_mem[ki] : tms_pkg::SPACE;
                        end
                        if (cfg_dir) p = (p == 0) ? r - 1 : p - 1;
                        else         p = (p + 1 >= r) ? 0 : p + 1;
                        ring_pos = p & 6'h3F;
                    end
                    for (i = 0; i < w; i++) begin
                        gw.column = i[tms_pkg::COL_W-1:0];
                        gw.glyph  = win_mem[i];
                        gw.last   = (i + 1 == w);
                        glyph_q.push_back(gw);
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        glyph_word_t want;
        glyph_word_t got;
        if (!aresetn) begin
            cfg_len    = 7'd1;
            cfg_width  = 7'd16;
            cfg_period = 8'd0;
            cfg_dir    = 1'b0;
            restart_scroll();
            glyph_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (tms_pkg::reg_idx_t'(cfg_addr))
                    tms_pkg::REG_TEXT_LENGTH:  cfg_len    = cfg_wdata[tms_pkg::LEN_W-1:0];
                    tms_pkg::REG_WINDOW_WIDTH: cfg_width  = cfg_wdata[tms_pkg::LEN_W-1:0];
                    tms_pkg::REG_PERIOD:       cfg_period = cfg_wdata;
                    tms_pkg::REG_DIRECTION:    cfg_dir    = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                advance_marquee(tms_pkg::kind_t'(s_tuser), s_tdata[5:0], s_tdata[13:6]);
            if (m_tvalid && m_tready) begin
                got.column = m_tdata[5:0];
                got.glyph  = m_tdata[13:6];
                got.last   = m_tlast;
                glyphs_seen++;
                if (m_tlast === 1'b1) frames_seen++;
                // words print as column/glyph/last
                if (glyph_q.size() == 0) begin
                    errors++;
                    if (errors <= 30)
                        $display("%0t ns: expected no word, got %0d/%02h/%0b",
                                 $realtime, got.column, got.glyph, got.last);
                end else begin
                    want = glyph_q.pop_front();
                    if (got.column !== want.column || got.glyph !== want.glyph ||
                        got.last !== want.last) begin
                        errors++;
                        if (errors <= 30)
                            $display("%0t ns: expected %0d/%02h/%0b, got %0d/%02h/%0b",
                                     $realtime, want.column, want.glyph, want.last,
                                     got.column, got.glyph, got.last);
                    end
                end
            end
        end
        pending = glyph_q.size();
    end

endmodule

FILE: bench/tb_text_marquee_scroller.sv
// ----------------------------------------------------------------------------
// tb_text_marquee_scroller
// Stimulus and verdict for the marquee scroller: directed text writes, ticks
// and restarts, then random words under a series of register settings, with
// bursty input, a stalling output side and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_marquee_scroller;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 16;
    localparam int NUM_SETTINGS = 9;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;
    wire         m_tlast;

    int errors, pending, frames_seen, glyphs_seen;

    // register settings walked after the directed part: length, width, period, direction
    int set_len   [NUM_SETTINGS] = '{5, 40, 3, 64, 0, 127, 1, 20, 12};
    int set_width [NUM_SETTINGS] = '{8, 8, 4, 64, 0, 127, 64, 1, 30};
    int set_per   [NUM_SETTINGS] = '{0, 1, 0, 0, 255, 3, 0, 2, 0};
    int set_dir   [NUM_SETTINGS] = '{0, 1, 0, 1, 0, 0, 1, 1, 0};
    int set_items [NUM_SETTINGS] = '{12, 12, 12, 10, 6, 12, 12, 12, 14};

    bit text_known [tms_pkg::MAX_TEXT];
    int burst_left = 0;
    int words_sent = 0;
    int settings_run = 0;
    int cycles = 0;

    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int rx_mode = 0;
    int rx_left = 0;
    int rx_phase = 0;

    always #2 aclk = ~aclk;

    text_marquee_scroller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    marquee_frame_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .errors      (errors),
        .pending     (pending),
        .frames_seen (frames_seen),
        .glyphs_seen (glyphs_seen)
    );

    // receiver: stall pattern changes every stretch; long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = 400;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                2: m_tready <= ($urandom_range(0, 7) != 0);
                default: begin
                    m_tready <= (rx_phase == 0);
                    rx_phase = (rx_phase + 1) % 3;
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still pending", cycles, pending);
            $display("** text_marquee_scroller: FAILED **");
            $finish;
        end
    end

    // offer one word and hold it until accepted; bursts mostly separated by gaps
    task automatic send_word(input tms_pkg::kind_t k, input logic [5:0] idx,
                             input logic [7:0] ch);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {2'b00, ch, idx};
        if (k == tms_pkg::KIND_WRITE) text_known[idx] = 1'b1;
        words_sent++;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_tick();
        send_word(tms_pkg::KIND_TICK, 6'($urandom), 8'($urandom));
    endtask

    // stop offering, wait for every frame, then let write-back finish
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input tms_pkg::reg_idx_t r, input logic [7:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(posedge aclk);
    endtask

    // program all registers, then make sure every text entry in use is written
    task automatic configure(input int len, input int w, input int per, input int dir);
        int span;
        write_reg(tms_pkg::REG_TEXT_LENGTH, 8'(len));
        write_reg(tms_pkg::REG_WINDOW_WIDTH, 8'(w));
        write_reg(tms_pkg::REG_PERIOD, 8'(per));
        write_reg(tms_pkg::REG_DIRECTION, 8'(dir));
        cfg_wr_en <= 1'b0;
        settings_run++;
        span = len & 8'h7F;
        if (span == 0) span = 1;
        if (span > tms_pkg::MAX_TEXT) span = tms_pkg::MAX_TEXT;
        for (int i = 0; i < span; i++)
            if (!text_known[i]) send_word(tms_pkg::KIND_WRITE, 6'(i), 8'($urandom));
    endtask

    // mostly ticks, with text edits, restarts and some unknown-kind noise
    task automatic run_random(input int n);
        int done;
        int pick;
        done = 0;
        while (done < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                send_tick();
                done++;
            end else if (pick < 84) begin
                send_word(tms_pkg::KIND_WRITE, 6'($urandom_range(0, 63)), 8'($urandom));
                done++;
            end else if (pick < 94) begin
                send_word(tms_pkg::KIND_RESTART, 6'($urandom), 8'($urandom));
                done++;
            end else begin
                send_word(tms_pkg::KIND_NONE, 6'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: one-character text, 16 columns, no period, leftward
        send_word(tms_pkg::KIND_WRITE, 6'd0, 8'h4D);
        send_word(tms_pkg::KIND_WRITE, 6'd63, 8'hFF);
        send_word(tms_pkg::KIND_WRITE, 6'd1, 8'h00);
        send_word(tms_pkg::KIND_NONE, 6'h3F, 8'hFF);
        send_word(tms_pkg::KIND_TICK, 6'h3F, 8'hFF);
        send_tick();
        send_tick();
        send_word(tms_pkg::KIND_RESTART, 6'd0, 8'h00);
        send_word(tms_pkg::KIND_NONE, 6'd0, 8'h00);
        send_tick();
        send_tick();
        settle();

        // rightward shift-in with a skip period
        configure(3, 5, 2, 1);
        send_word(tms_pkg::KIND_RESTART, 6'd0, 8'h00);
        repeat (8) send_tick();
        settle();

        // text longer than the window
        configure(8, 3, 0, 0);
        send_word(tms_pkg::KIND_RESTART, 6'd0, 8'h00);
        repeat (6) send_tick();
        settle();

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            configure(set_len[s], set_width[s], set_per[s], set_dir[s]);
            if (s == 3) begin
                // output held off while full-width frames keep coming
                hold_req++;
                repeat (12) send_tick();
            end
            run_random(set_items[s]);
            settle();
        end

        repeat (64) @(posedge aclk);
        $display("covered %0d input words over %0d register settings", words_sent,
                 settings_run);
        $display("checked %0d window words in %0d frames, %0d errors", glyphs_seen,
                 frames_seen, errors);
        if (errors == 0)
            $display("** text_marquee_scroller: PASSED **");
        else
            $display("** text_marquee_scroller: FAILED **");
        $finish;
    end

endmodule
